// ===== rtl/core/bech32_string_decoder_defines.svh =====
// assertion macros used by the checker file
`ifndef BECH32_STRING_DECODER_DEFINES_SVH
`define BECH32_STRING_DECODER_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define B32D_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the cycle after the trigger
`define B32D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/b32d_pkg.sv =====
package b32d_pkg;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam int MIN_LEN       = 8;
  localparam int CHECKSUM_SYMS = 6;
  localparam int FIELD_W       = 7;

  // character classes
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_Z   = 8'h7a;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_Z    = 8'h5a;
  localparam logic [7:0] CH_SEP     = 8'h31;
  localparam logic [7:0] CH_MIN     = 8'h21;
  localparam logic [7:0] CH_MAX     = 8'h7e;
  localparam logic [6:0] CASE_DELTA = 7'h20;

  localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  // checksum generator and residues
  localparam logic [29:0] GEN [5] = '{30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa,
                                     30'h3d4233dd, 30'h2a1462b3};
  localparam logic [29:0] RES_BECH32  = 30'h1;
  localparam logic [29:0] RES_BECH32M = 30'h2bc830a3;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_LENGTH,
    ERR_RANGE,
    ERR_CASE,
    ERR_SEPARATOR,
    ERR_DATA_CHAR,
    ERR_CHECKSUM
  } err_t;

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_HIGH,
    STEP_ZERO,
    STEP_LOW,
    STEP_DATA
  } step_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_HIGH,
    S_ZERO,
    S_LOW,
    S_DATA,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic       command;
    logic [7:0] char_code;
    logic       last_char;
    logic [6:0] read_index;
  } b32d_in_t;

  typedef struct packed {
    logic       is_read_reply;
    logic       valid_res;
    logic       variant;
    logic [2:0] error_code;
    logic [6:0] prefix_length;
    logic [6:0] payload_length;
    logic [6:0] read_value;
    logic       read_is_prefix;
  } b32d_out_t;

  // controller to datapath
  typedef struct packed {
    logic  load_char;
    logic  read_issue;
    logic  pass_start;
    step_t step;
    logic  emit_read;
    logic  emit_status;
  } b32d_cmd_t;

  // datapath to controller
  typedef struct packed {
    err_t early_err;
    logic at_prefix_end;
    logic at_end;
    logic out_busy;
  } b32d_stat_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] val;
  } map_t;

  function automatic logic [6:0] to_lower(input logic [6:0] c);
    logic [6:0] r;
    r = c;
    if ({1'b0, c} >= CH_UP_A && {1'b0, c} <= CH_UP_Z) r = c + CASE_DELTA;
    return r;
  endfunction

  function automatic map_t map_char(input logic [6:0] c);
    map_t r;
    r = '0;
    for (int k = 0; k < 32; k++) begin
      if (CHARSET[8*(31-k) +: 8] == {1'b0, c}) begin
        r.ok  = 1'b1;
        r.val = 5'(k);
      end
    end
    return r;
  endfunction

  function automatic logic [29:0] pm_step(input logic [29:0] acc, input logic [4:0] v);
    logic [4:0]  top;
    logic [29:0] r;
    top = acc[29:25];
    r   = {acc[24:0], v};
    for (int j = 0; j < 5; j++) begin
      if (top[j]) r = r ^ GEN[j];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/b32d_chan_if.sv =====
interface b32d_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/b32d_ram.sv =====
module b32d_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 90
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/b32d_ctrl.sv =====
module b32d_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_command,
  input  logic                   in_last,
  input  b32d_pkg::b32d_stat_t   stat,
  output logic                   in_ready,
  output b32d_pkg::b32d_cmd_t    cmd
);
  import b32d_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.step   = STEP_NONE;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_command == CMD_READ) begin
            cmd.read_issue = 1'b1;
            state_next     = S_READ;
          end else begin
            cmd.load_char = 1'b1;
            if (in_last) state_next = S_CHECK;
          end
        end
      end
      S_READ: begin
        if (!stat.out_busy) begin
          cmd.emit_read = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_CHECK: begin
        if (stat.early_err != ERR_NONE) begin
          state_next = S_FINISH;
        end else begin
          cmd.pass_start = 1'b1;
          state_next     = S_HIGH;
        end
      end
      S_HIGH: begin
        cmd.step = STEP_HIGH;
        if (stat.at_prefix_end) state_next = S_ZERO;
      end
      S_ZERO: begin
        cmd.step   = STEP_ZERO;
        state_next = S_LOW;
      end
      S_LOW: begin
        cmd.step = STEP_LOW;
        if (stat.at_prefix_end) state_next = S_DATA;
      end
      S_DATA: begin
        cmd.step = STEP_DATA;
        if (stat.at_end) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.emit_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

// ===== rtl/core/b32d_dpath.sv =====
module b32d_dpath #(
  parameter int MAX_LEN = 90
) (
  input  logic                   clk,
  input  logic                   rst,
  input  b32d_pkg::b32d_cmd_t    cmd,
  input  b32d_pkg::b32d_in_t     in_data,
  input  logic                   out_ready,
  output b32d_pkg::b32d_stat_t   stat,
  output logic                   out_valid,
  output b32d_pkg::b32d_out_t    out_data
);
  import b32d_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  // load tracking
  logic [CW-1:0] count;
  logic          saw_lower, saw_upper, saw_bad, len_ovf;
  logic          sep_seen;
  logic [AW-1:0] sep_pos;

  // checksum pass
  logic [29:0]   acc, acc_next;
  logic          bad_data;
  logic [AW-1:0] idx, addr_d;
  step_t         tag;

  // decoded lengths and read bookkeeping
  logic [6:0]    dec_pl, dec_dl;
  logic          rd_ok, rd_isp;

  // ram ports
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [6:0]    wdata, q;

  logic          room;
  logic [6:0]    lc;
  map_t          mapped;
  err_t          early_err, fin_err;
  logic [6:0]    hl, dl, payload;
  logic          chk_ok, is_m;

  // read position
  logic [6:0]    rel;
  logic [7:0]    rd_pos;
  logic          rd_ok_c, rd_isp_c;

  b32d_ram #(.WIDTH(FIELD_W), .DEPTH(MAX_LEN)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (q)
  );

  assign room = count < CW'(MAX_LEN);
  assign lc     = to_lower(q);
  assign mapped = map_char(lc);

  // string rule checks on the finished load
  assign hl      = 7'(sep_pos);
  assign dl      = 7'(count) - hl - 7'd1;
  assign payload = dl - 7'(CHECKSUM_SYMS);

  always_comb begin
    if (len_ovf || count < CW'(MIN_LEN))              early_err = ERR_LENGTH;
    else if (saw_bad)                                 early_err = ERR_RANGE;
    else if (saw_lower && saw_upper)                  early_err = ERR_CASE;
    else if (!sep_seen || sep_pos == '0 ||
             8'(sep_pos) + 8'(CHECKSUM_SYMS + 1) > 8'(count))
                                                      early_err = ERR_SEPARATOR;
    else                                              early_err = ERR_NONE;
  end

  // final verdict
  assign is_m = acc == RES_BECH32M;
  always_comb begin
    if (early_err != ERR_NONE)              fin_err = early_err;
    else if (bad_data)                      fin_err = ERR_DATA_CHAR;
    else if (acc == RES_BECH32 || is_m)     fin_err = ERR_NONE;
    else                                    fin_err = ERR_CHECKSUM;
  end
  assign chk_ok = fin_err == ERR_NONE;

  // read index to store position
  assign rel = in_data.read_index - dec_pl;
  always_comb begin
    rd_ok_c  = 1'b0;
    rd_isp_c = 1'b0;
    rd_pos   = {1'b0, in_data.read_index};
    if (in_data.read_index < dec_pl) begin
      rd_ok_c  = 1'b1;
      rd_isp_c = 1'b1;
    end else if (rel < dec_dl) begin
      rd_ok_c = 1'b1;
      rd_pos  = {1'b0, in_data.read_index} + 8'd1;
    end
    if (rd_pos >= 8'(MAX_LEN)) begin
      rd_ok_c  = 1'b0;
      rd_isp_c = 1'b0;
    end
  end

  // store ports
  always_comb begin
    we    = 1'b0;
    waddr = addr_d;
    wdata = lc;
    if (cmd.load_char) begin
      we    = room;
      waddr = count[AW-1:0];
      wdata = in_data.char_code[6:0];
    end else begin
      case (tag)
        STEP_HIGH: we = 1'b1;
        STEP_DATA: begin
          we    = mapped.ok;
          wdata = {2'b00, mapped.val};
        end
        default: we = 1'b0;
      endcase
    end
    re    = cmd.read_issue || cmd.step == STEP_HIGH || cmd.step == STEP_LOW ||
            cmd.step == STEP_DATA;
    raddr = cmd.read_issue ? rd_pos[AW-1:0] : idx;
  end

  // one polymod step per cycle, on the value the store returned or on a zero
  always_comb begin
    case (tag)
      STEP_HIGH: acc_next = pm_step(acc, {3'b000, lc[6:5]});
      STEP_ZERO: acc_next = pm_step(acc, 5'd0);
      STEP_LOW:  acc_next = pm_step(acc, lc[4:0]);
      STEP_DATA: acc_next = pm_step(acc, mapped.val);
      default:   acc_next = acc;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      saw_lower <= 1'b0;
      saw_upper <= 1'b0;
      saw_bad   <= 1'b0;
      len_ovf   <= 1'b0;
      sep_seen  <= 1'b0;
      sep_pos   <= '0;
      acc       <= RES_BECH32;
      bad_data  <= 1'b0;
      dec_pl    <= '0;
      dec_dl    <= '0;
      tag       <= STEP_NONE;
      out_valid <= 1'b0;
    end else begin
      tag <= cmd.step;
      acc <= acc_next;
      if (tag == STEP_DATA && !mapped.ok) bad_data <= 1'b1;
      if (cmd.load_char) begin
        if (room) begin
          if (in_data.char_code < CH_MIN || in_data.char_code > CH_MAX) saw_bad <= 1'b1;
          if (in_data.char_code inside {[CH_LOW_A:CH_LOW_Z]}) saw_lower <= 1'b1;
          if (in_data.char_code inside {[CH_UP_A:CH_UP_Z]}) saw_upper <= 1'b1;
          if (in_data.char_code == CH_SEP) begin
            sep_seen <= 1'b1;
            sep_pos  <= count[AW-1:0];
          end
          count <= count + 1'b1;
        end else begin
          len_ovf <= 1'b1;
        end
      end
      if (cmd.pass_start) begin
        acc      <= RES_BECH32;
        bad_data <= 1'b0;
      end
      if (cmd.emit_status) begin
        dec_pl    <= chk_ok ? hl : 7'd0;
        dec_dl    <= chk_ok ? payload : 7'd0;
        count     <= '0;
        saw_lower <= 1'b0;
        saw_upper <= 1'b0;
        saw_bad   <= 1'b0;
        len_ovf   <= 1'b0;
        sep_seen  <= 1'b0;
        sep_pos   <= '0;
        acc       <= RES_BECH32;
      end
      if (cmd.emit_status || cmd.emit_read) out_valid <= 1'b1;
      else if (out_ready)                   out_valid <= 1'b0;
    end
  end

  // pass address walk, read bookkeeping and result register
  always_ff @(posedge clk) begin
    addr_d <= idx;
    if (cmd.pass_start) begin
      idx <= '0;
    end else begin
      case (cmd.step)
        STEP_HIGH: idx <= idx + 1'b1;
        STEP_ZERO: idx <= '0;
        STEP_LOW:  idx <= stat.at_prefix_end ? sep_pos + 1'b1 : idx + 1'b1;
        STEP_DATA: idx <= idx + 1'b1;
        default:   idx <= idx;
      endcase
    end
    if (cmd.read_issue) begin
      rd_ok  <= rd_ok_c;
      rd_isp <= rd_isp_c;
    end
    if (cmd.emit_status) begin
      out_data                <= '0;
      out_data.valid_res      <= chk_ok;
      out_data.variant        <= chk_ok && is_m;
      out_data.error_code     <= fin_err;
      out_data.prefix_length  <= chk_ok ? hl : 7'd0;
      out_data.payload_length <= chk_ok ? payload : 7'd0;
    end else if (cmd.emit_read) begin
      out_data                <= '0;
      out_data.is_read_reply  <= 1'b1;
      out_data.valid_res      <= rd_ok;
      out_data.prefix_length  <= dec_pl;
      out_data.payload_length <= dec_dl;
      out_data.read_value     <= rd_ok ? q : 7'd0;
      out_data.read_is_prefix <= rd_isp;
    end
  end

  assign stat.early_err     = early_err;
  assign stat.at_prefix_end = idx == sep_pos - 1'b1;
  assign stat.at_end        = idx == AW'(count - 1'b1);
  assign stat.out_busy      = out_valid && !out_ready;
endmodule

// ===== rtl/core/bech32_string_decoder.sv =====
// bech32 / bech32m address decoder with checksum check
// req channel: command 0 loads one character of the string, last_char marks
// the final one; command 1 reads one decoded entry by read_index (prefix
// characters first, then data values without the checksum symbols).
// resp channel: one status item per string (after its last character) and
// one reply item per read; loads without last_char give no item.
// loads are taken back to back while idle. after the last character the block
// checks the string rules and then runs the polymod one symbol per cycle over
// the prefix high bits, a zero, the prefix low bits and the data part (every
// character after the separator); the pass is bounded by the single store read
// port feeding the one-step polymod unit, and the status item then passes the
// drain and finish states. strings failing the early checks skip the pass.
// a read reply is offered from the output register after the read state;
// no new request is taken until that reply has been emitted.
// reset clears all load tracking and the decoded lengths; the character store
// itself is not cleared and needs no clearing pass.
// when resp is stalled the result waits in the output register; further
// loads are still taken, and the block holds before the next result.
module bech32_string_decoder #(
  parameter int MAX_LEN = 90
) (
  input logic       clk,
  input logic       rst,
  b32d_chan_if.sink   req,
  b32d_chan_if.source resp
);
  import b32d_pkg::*;

  b32d_cmd_t  cmd;
  b32d_stat_t stat;

  b32d_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_command (req.data.command),
    .in_last    (req.data.last_char),
    .stat       (stat),
    .in_ready   (req.ready),
    .cmd        (cmd)
  );

  b32d_dpath #(.MAX_LEN(MAX_LEN)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (req.data),
    .out_ready (resp.ready),
    .stat      (stat),
    .out_valid (resp.valid),
    .out_data  (resp.data)
  );
endmodule

// ===== rtl/core/b32d_checker.sv =====
`include "bech32_string_decoder_defines.svh"

module b32d_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input b32d_pkg::b32d_out_t out_data
);
  import b32d_pkg::*;

  // a stalled result stays offered
  `B32D_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // read replies carry no status
  `B32D_ASSERT_IMPL(a_reply_clean, out_valid && out_data.is_read_reply, out_data.error_code == 3'(ERR_NONE) && !out_data.variant, "read reply carries status fields")

  // status items: valid exactly when no error, no read fields
  `B32D_ASSERT_IMPL(a_status_form, out_valid && !out_data.is_read_reply, out_data.valid_res == (out_data.error_code == 3'(ERR_NONE)) && out_data.read_value == 7'd0 && !out_data.read_is_prefix, "malformed status item")

  // a prefix character only comes from a valid read
  `B32D_ASSERT_IMPL(a_prefix_read, out_valid && out_data.read_is_prefix, out_data.valid_res && out_data.is_read_reply && out_data.prefix_length != 7'd0, "prefix flag on bad read")
endmodule

bind bech32_string_decoder b32d_checker u_b32d_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (resp.valid),
  .out_ready (resp.ready),
  .out_data  (resp.data)
);
